@@ design/elic_pkg.sv @@
// Package for the lagged exponentially weighted correlation block.
// Widths, register indexes and fill codes used by the top level.
package elic_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 48;
    localparam int MAX_LAG  = 64;
    localparam int HIST_AW  = 6;
    localparam int HIST_W   = SAMPLE_W + 1;   // sample plus missing flag
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 16;

    localparam logic [CFG_IW-1:0] CFG_DECAY = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_LAG   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_WARM  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_FILL  = 3'd3;

    localparam logic [1:0] FILL_ZERO  = 2'd0;
    localparam logic [1:0] FILL_FIRST = 2'd1;
    localparam logic [1:0] FILL_MISS  = 2'd2;

    localparam logic [6:0] LAG_MAX = 7'd64;

endpackage

@@ design/elic_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module elic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/ewm_lagged_instant_correlation_top.sv @@
// Lagged EW moving correlation. One item at a time; one result per item.
// A valid result passes the product, sum update, radicand, square root and
// divide steps on one 26x26 multiplier and a shift-subtract unit. A warmup
// item skips radicand, root and divide; a missing pair also skips the products.
// s_tready returns when the result is loaded into the output register.
// aresetn (sync, low): sums, sample index, history pointer, state, config and output valid reset.
module ewm_lagged_instant_correlation_top import elic_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // x_sample, y_sample
    input  logic [2:0]        s_tuser,   // x_missing, y_missing, series_start
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // correlation
    output logic              m_tuser,   // corr_valid
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_LOOK = 4'd1;
    localparam logic [3:0] ST_PROD = 4'd2;
    localparam logic [3:0] ST_SUM  = 4'd3;
    localparam logic [3:0] ST_SQP  = 4'd4;
    localparam logic [3:0] ST_SQRT = 4'd5;
    localparam logic [3:0] ST_ABS  = 4'd6;
    localparam logic [3:0] ST_DIV0 = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    localparam logic signed [95:0] ROUND_HALF = 96'sd32768;

    logic [3:0]  state_reg;
    logic [15:0] decay_reg;
    logic [6:0]  lag_reg;
    logic [15:0] warm_reg;
    logic [1:0]  fill_reg;

    logic signed [SAMPLE_W-1:0] x_reg, cy_reg, ly_reg, fy_reg;
    logic xm_reg, cym_reg, fym_reg, miss_reg, warm_ok_reg;
    logic [15:0]        idx_reg;
    logic [HIST_AW-1:0] hp_reg;

    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [31:0]      p_reg [3];
    logic signed [51:0]      mul_reg;
    logic signed [95:0]      acc_reg;
    logic [1:0]  j_reg;
    logic [5:0]  k_reg;
    logic        h_reg;
    logic [47:0] root_reg;
    logic [51:0] rem_reg;
    logic [16:0] q_reg;
    logic        neg_reg, res_valid_reg;
    logic        mt_valid_reg, m_user_reg;
    logic [15:0] m_data_reg;

    // combinational
    logic        accept_in;
    logic [6:0]  lag_eff;
    logic [HIST_AW-1:0] rd_addr;
    logic [HIST_W-1:0]  ram_rdata;
    logic signed [SAMPLE_W-1:0] ly_next;
    logic        lm_next;
    logic signed [25:0] mul_a, mul_b;
    logic signed [51:0] mul_prod;
    logic [5:0]  sh_amt;
    logic signed [95:0] term, acc_sum;
    logic        last_op;
    logic [51:0] sq_rem_sh, sq_trial, dv_rem_sh;
    logic [47:0] mag;
    logic [62:0] num;
    logic [15:0] corr_next;
    logic [16:0] c17;

    assign accept_in = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mt_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign lag_eff = (lag_reg > LAG_MAX) ? LAG_MAX : lag_reg;
    assign rd_addr = hp_reg - lag_eff[HIST_AW-1:0];

    elic_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_LAG)
    ) u_hist (
        .clk   (aclk),
        .we    (state_reg == ST_LOOK),
        .waddr (hp_reg),
        .wdata ({cym_reg, cy_reg}),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // lagged y selection
    always_comb begin
        if (lag_eff == 7'd0) begin
            ly_next = cy_reg;
            lm_next = cym_reg;
        end else if ({9'd0, lag_eff} > idx_reg) begin
            if (fill_reg == FILL_FIRST) begin
                ly_next = (idx_reg == 16'd0) ? cy_reg : fy_reg;
                lm_next = (idx_reg == 16'd0) ? cym_reg : fym_reg;
            end else begin
                ly_next = '0;
                lm_next = (fill_reg == FILL_MISS);
            end
        end else begin
            ly_next = ram_rdata[SAMPLE_W-1:0];
            lm_next = ram_rdata[HIST_W-1];
        end
    end

    // operand select for the shared multiplier
    assign c17 = 17'h10000 - {1'b0, decay_reg};

    always_comb begin
        logic signed [SUM_W-1:0] s_sel;
        logic signed [31:0]      p_sel;
        s_sel  = sum_reg[j_reg];
        p_sel  = p_reg[j_reg];
        mul_a  = '0;
        mul_b  = '0;
        sh_amt = 6'd0;
        case (state_reg)
            ST_PROD: begin
                case (k_reg[1:0])
                    2'd0: begin
                        mul_a = 26'(x_reg);
                        mul_b = 26'(ly_reg);
                    end
                    2'd1: begin
                        mul_a = 26'(x_reg);
                        mul_b = 26'(x_reg);
                    end
                    default: begin
                        mul_a = 26'(ly_reg);
                        mul_b = 26'(ly_reg);
                    end
                endcase
            end
            ST_SUM: begin
                case (k_reg[1:0])
                    2'd0: begin
                        mul_a = 26'($signed({1'b0, decay_reg}));
                        mul_b = 26'($signed({1'b0, s_sel[23:0]}));
                    end
                    2'd1: begin
                        mul_a  = 26'($signed({1'b0, decay_reg}));
                        mul_b  = 26'($signed(s_sel[47:24]));
                        sh_amt = 6'd24;
                    end
                    2'd2: begin
                        mul_a  = 26'($signed({1'b0, c17}));
                        mul_b  = 26'($signed({1'b0, p_sel[15:0]}));
                        sh_amt = 6'd16;
                    end
                    default: begin
                        mul_a  = 26'($signed({1'b0, c17}));
                        mul_b  = 26'($signed(p_sel[31:16]));
                        sh_amt = 6'd32;
                    end
                endcase
            end
            ST_SQP: begin
                case (k_reg[1:0])
                    2'd0: begin
                        mul_a = 26'($signed({1'b0, sum_reg[1][23:0]}));
                        mul_b = 26'($signed({1'b0, sum_reg[2][23:0]}));
                    end
                    2'd1: begin
                        mul_a  = 26'($signed({1'b0, sum_reg[1][23:0]}));
                        mul_b  = 26'($signed({1'b0, sum_reg[2][47:24]}));
                        sh_amt = 6'd24;
                    end
                    2'd2: begin
                        mul_a  = 26'($signed({1'b0, sum_reg[1][47:24]}));
                        mul_b  = 26'($signed({1'b0, sum_reg[2][23:0]}));
                        sh_amt = 6'd24;
                    end
                    default: begin
                        mul_a  = 26'($signed({1'b0, sum_reg[1][47:24]}));
                        mul_b  = 26'($signed({1'b0, sum_reg[2][47:24]}));
                        sh_amt = 6'd48;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;
    assign term     = 96'(mul_reg) <<< sh_amt;
    assign acc_sum  = acc_reg + term;

    always_comb begin
        case (state_reg)
            ST_PROD: last_op = (k_reg == 6'd2);
            ST_SUM:  last_op = miss_reg ? (k_reg == 6'd1) : (k_reg == 6'd3);
            ST_SQP:  last_op = (k_reg == 6'd3);
            default: last_op = 1'b0;
        endcase
    end

    // restoring square root, one result bit per cycle
    assign sq_rem_sh = {rem_reg[49:0], acc_reg[95:94]};
    assign sq_trial  = {2'b00, root_reg, 2'b01};
    // restoring divide, one quotient bit per cycle
    assign dv_rem_sh = {rem_reg[50:0], acc_reg[16]};

    assign mag = sum_reg[0][SUM_W-1] ? 48'(-sum_reg[0]) : 48'(sum_reg[0]);
    assign num = acc_reg[62:0] + {16'd0, root_reg[47:1]};

    always_comb begin
        if (neg_reg) begin
            corr_next = (q_reg > 17'd32768) ? 16'h8000 : 16'(-q_reg);
        end else begin
            corr_next = (q_reg > 17'd32767) ? 16'h7FFF : q_reg[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            decay_reg    <= 16'd32768;
            lag_reg      <= 7'd0;
            warm_reg     <= 16'd0;
            fill_reg     <= FILL_ZERO;
            sum_reg[0]   <= '0;
            sum_reg[1]   <= '0;
            sum_reg[2]   <= '0;
            idx_reg      <= '0;
            hp_reg       <= '0;
            mt_valid_reg <= 1'b0;
            j_reg        <= '0;
            k_reg        <= '0;
            h_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DECAY: decay_reg <= cfg_data;
                    CFG_LAG:   lag_reg   <= cfg_data[6:0];
                    CFG_WARM:  warm_reg  <= cfg_data;
                    CFG_FILL:  fill_reg  <= cfg_data[1:0];
                    default:   ;
                endcase
            end
            // ST_OUT reloads the output itself
            if (mt_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                mt_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept_in) begin
                        x_reg   <= s_tdata[15:0];
                        cy_reg  <= s_tdata[31:16];
                        xm_reg  <= s_tuser[0];
                        cym_reg <= s_tuser[1];
                        if (s_tuser[2]) begin
                            sum_reg[0] <= '0;
                            sum_reg[1] <= '0;
                            sum_reg[2] <= '0;
                            idx_reg    <= '0;
                        end
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    ly_reg   <= ly_next;
                    miss_reg <= xm_reg || lm_next;
                    warm_ok_reg <= (idx_reg >= warm_reg);
                    if (idx_reg == 16'd0) begin
                        fy_reg  <= cy_reg;
                        fym_reg <= cym_reg;
                    end
                    hp_reg <= hp_reg + 1'b1;
                    if (idx_reg != 16'hFFFF) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    k_reg   <= '0;
                    j_reg   <= '0;
                    h_reg   <= 1'b0;
                    acc_reg <= ROUND_HALF;
                    state_reg <= (xm_reg || lm_next) ? ST_SUM : ST_PROD;
                end
                ST_PROD, ST_SUM, ST_SQP: begin
                    if (!h_reg) begin
                        mul_reg <= mul_prod;
                        h_reg   <= 1'b1;
                    end else begin
                        h_reg <= 1'b0;
                        k_reg <= last_op ? 6'd0 : k_reg + 1'b1;
                        if (state_reg == ST_PROD) begin
                            p_reg[k_reg[1:0]] <= mul_reg[31:0];
                            if (last_op) begin
                                state_reg <= ST_SUM;
                            end
                        end else if (state_reg == ST_SUM) begin
                            if (last_op) begin
                                sum_reg[j_reg] <= acc_sum[63:16];
                                j_reg   <= j_reg + 1'b1;
                                if (j_reg == 2'd2) begin
                                    if (miss_reg || !warm_ok_reg) begin
                                        q_reg         <= '0;
                                        neg_reg       <= 1'b0;
                                        res_valid_reg <= 1'b0;
                                        state_reg     <= ST_OUT;
                                    end else begin
                                        acc_reg   <= '0;
                                        state_reg <= ST_SQP;
                                    end
                                end else begin
                                    acc_reg <= ROUND_HALF;
                                end
                            end else begin
                                acc_reg <= acc_sum;
                            end
                        end else begin
                            acc_reg <= acc_sum;
                            if (last_op) begin
                                root_reg  <= '0;
                                rem_reg   <= '0;
                                state_reg <= ST_SQRT;
                            end
                        end
                    end
                end
                ST_SQRT: begin
                    if (sq_rem_sh >= sq_trial) begin
                        rem_reg  <= sq_rem_sh - sq_trial;
                        root_reg <= {root_reg[46:0], 1'b1};
                    end else begin
                        rem_reg  <= sq_rem_sh;
                        root_reg <= {root_reg[46:0], 1'b0};
                    end
                    acc_reg <= acc_reg <<< 2;
                    if (k_reg == 6'd47) begin
                        k_reg     <= '0;
                        state_reg <= ST_ABS;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_ABS: begin
                    if (root_reg == 48'd0) begin
                        root_reg <= 48'd1;
                    end
                    neg_reg   <= sum_reg[0][SUM_W-1];
                    acc_reg   <= $signed(96'({mag, 15'd0}));
                    state_reg <= ST_DIV0;
                end
                ST_DIV0: begin
                    acc_reg       <= $signed(96'(num));
                    res_valid_reg <= 1'b1;
                    k_reg         <= '0;
                    if ({2'b00, num[62:17]} >= root_reg) begin
                        q_reg     <= 17'h1FFFF;
                        state_reg <= ST_OUT;
                    end else begin
                        q_reg     <= '0;
                        rem_reg   <= {6'd0, num[62:17]};
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (dv_rem_sh >= {4'd0, root_reg}) begin
                        rem_reg <= dv_rem_sh - {4'd0, root_reg};
                        q_reg   <= {q_reg[15:0], 1'b1};
                    end else begin
                        rem_reg <= dv_rem_sh;
                        q_reg   <= {q_reg[15:0], 1'b0};
                    end
                    acc_reg <= acc_reg <<< 1;
                    k_reg   <= k_reg + 1'b1;
                    if (k_reg == 6'd16) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!mt_valid_reg || m_tready) begin
                        mt_valid_reg <= 1'b1;
                        m_data_reg   <= corr_next;
                        m_user_reg   <= res_valid_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/elic_checker.sv @@
// Port-level checks for the lagged EW correlation top level.
// Bound to ewm_lagged_instant_correlation_top; no other dependencies.
module elic_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // one item in flight: input closes right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready stayed high after accept");

    // an invalid result carries a zero correlation
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 16'd0))
        else $error("invalid result with nonzero correlation");

    // the result waits while the output is stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ewm_lagged_instant_correlation_top elic_checker u_elic_checker (.*);
